>>> rtl/cntab_pkg.sv
// ---------------------------------------------------------------------------
// cntab_pkg
// shared types and constants of the compacting name table
// ---------------------------------------------------------------------------
`default_nettype none

package cntab_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int KEY_W       = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CREATED   = 3'd0,
        ST_EXISTS    = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FOUND     = 3'd4,
        ST_FULL      = 3'd5,
        ST_LIST      = 3'd6,
        ST_EMPTY     = 3'd7
    } status_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [KEY_W-1:0] key_out;
        logic             last;
    } rsp_t;

    // command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_SHIFT,
        CELL_WRITE,
        CELL_ROTATE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t        cmd;
        logic [CNT_W-1:0] count;
        logic [KEY_W-1:0] req_key;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/cntab_cell.sv
// ---------------------------------------------------------------------------
// cntab_cell
// one table slot: holds a key, compares it, writes it, shifts or rotates with its neighbor
// ---------------------------------------------------------------------------
`default_nettype none

module cntab_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cntab_pkg::cell_ctrl_t     ctrl,
    input  wire logic [cntab_pkg::IDX_W-1:0] idx,
    input  wire logic [cntab_pkg::KEY_W-1:0] nbr_key,
    input  wire logic [cntab_pkg::KEY_W-1:0] head_key,
    input  wire logic                      seen_in,
    output logic                           seen_out,
    output logic                           hit,
    output logic [cntab_pkg::KEY_W-1:0]    key
);
    import cntab_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             hit_reg;
    logic             hit_next;
    logic [CNT_W-1:0] idx_ext;
    logic             slot_valid;
    logic             is_tail;

    assign idx_ext    = CNT_W'(idx);
    assign slot_valid = idx_ext < ctrl.count;
    assign is_tail    = idx_ext == (ctrl.count - CNT_W'(1));
    assign seen_out   = seen_in | hit_reg;
    assign hit        = hit_reg;
    assign key        = key_reg;

    always_comb
    begin
        key_next = key_reg;
        hit_next = hit_reg;
        case (ctrl.cmd)
            CELL_CMP:
            begin
                hit_next = slot_valid && (key_reg == ctrl.req_key);
            end
            CELL_SHIFT:
            begin
                // close the gap at and above the deleted slot
                if (seen_out)
                begin
                    key_next = nbr_key;
                end
            end
            CELL_WRITE:
            begin
                if (idx_ext == ctrl.count)
                begin
                    key_next = ctrl.req_key;
                end
            end
            CELL_ROTATE:
            begin
                key_next = is_tail ? head_key : nbr_key;
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

>>> rtl/compacting_name_table_top.sv
// ---------------------------------------------------------------------------
// compacting_name_table_top
// ordered table of unique 64-bit name keys built as a chain of slot cells
// ---------------------------------------------------------------------------
// Create, delete and search each pass through three steps per request
// (accept, compare in all cells at once, execute). The result lands in the
// output register at the end of execute. The block is then back in idle and
// takes the next request even if that result has not yet been taken. Execute
// waits while the output register still holds an untaken result. List goes
// through the same steps and then, on a non-empty table, loads one stored
// entry at a time into the output register from the listing state, waiting
// on any output stall. The chain of cells rotates by one slot per output
// transfer, with the head cell feeding the output and moving to the tail, so
// after a full listing the table is back in its original order. Delete
// closes the gap in its execute step by shifting every cell above the match
// down by one. The block comes out of reset ready with an empty table; no
// clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module compacting_name_table_top (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire cntab_pkg::req_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output cntab_pkg::rsp_t      out_data
);
    import cntab_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC,
        S_LIST
    } state_t;

    state_t           state_reg, state_next;
    req_t             req_reg, req_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] list_idx_reg, list_idx_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_reg, out_next;

    cell_ctrl_t       ctrl;
    logic [KEY_W-1:0] cell_key [TABLE_DEPTH];
    logic [KEY_W-1:0] cell_nbr [TABLE_DEPTH];
    logic             seen     [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] hit_vec;
    logic             any_hit;
    logic             out_free;
    logic             list_last;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;
    // the end of the seen chain is the or of every cell's match
    assign any_hit   = seen[TABLE_DEPTH];
    assign list_last = CNT_W'(list_idx_reg) == (count_reg - CNT_W'(1));
    assign seen[0]   = 1'b0;

    // the chain: each cell sees its upper neighbor and the head of the table
    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            if (g == TABLE_DEPTH - 1)
            begin : g_top
                assign cell_nbr[g] = cell_key[g];
            end
            else
            begin : g_mid
                assign cell_nbr[g] = cell_key[g+1];
            end

            cntab_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .idx      (IDX_W'(g)),
                .nbr_key  (cell_nbr[g]),
                .head_key (cell_key[0]),
                .seen_in  (seen[g]),
                .seen_out (seen[g+1]),
                .hit      (hit_vec[g]),
                .key      (cell_key[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        list_idx_next  = list_idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl.cmd       = CELL_HOLD;
        ctrl.count     = count_reg;
        ctrl.req_key   = req_reg.key;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                ctrl.cmd   = CELL_CMP;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_next.key_out = req_reg.key;
                    out_next.last    = 1'b1;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                    case (req_reg.op)
                        OP_CREATE:
                        begin
                            if (any_hit)
                            begin
                                out_next.status = ST_EXISTS;
                            end
                            else if (count_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                out_next.status = ST_FULL;
                            end
                            else
                            begin
                                ctrl.cmd        = CELL_WRITE;
                                count_next      = count_reg + CNT_W'(1);
                                out_next.status = ST_CREATED;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (any_hit)
                            begin
                                ctrl.cmd        = CELL_SHIFT;
                                count_next      = count_reg - CNT_W'(1);
                                out_next.status = ST_DELETED;
                            end
                            else
                            begin
                                out_next.status = ST_NOT_FOUND;
                            end
                        end
                        OP_SEARCH:
                        begin
                            out_next.status = any_hit ? ST_FOUND : ST_NOT_FOUND;
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                out_next.status  = ST_EMPTY;
                                out_next.key_out = '0;
                            end
                            else
                            begin
                                // no transfer yet, the listing state emits
                                out_valid_next = out_valid_reg && !out_ready;
                                list_idx_next  = '0;
                                state_next     = S_LIST;
                            end
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    ctrl.cmd         = CELL_ROTATE;
                    out_next.status  = ST_LIST;
                    out_next.key_out = cell_key[0];
                    out_next.last    = list_last;
                    out_valid_next   = 1'b1;
                    if (list_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        list_idx_next = list_idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            count_reg     <= '0;
            list_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            count_reg     <= count_next;
            list_idx_reg  <= list_idx_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    // fill level never passes the table depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // listing only runs over a non-empty table
    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LIST |-> count_reg != '0)
        else $error("listing an empty table");

    // a confirmed delete drops exactly one entry
    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && out_free && req_reg.op == OP_DELETE && any_hit)
        |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("delete did not shrink table by one");

    // keys are unique, so at most one cell matches
    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> $onehot0(hit_vec))
        else $error("more than one cell matched");

    // an input transfer always starts a compare
    a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == S_CMP)
        else $error("accepted request did not start a compare");

endmodule

`default_nettype wire
